/* design/cta_pkg.sv */
// ----------------------------------------------------------------------------
// Centroid track association package
// Shared types, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cta_pkg;

	localparam int CTA_MAX_TRACKS     = 32;
	localparam int CTA_MAX_DETECTIONS = 32;

	localparam logic [15:0] CTA_FORGET_RESET = 16'd120;
	localparam logic [15:0] CTA_RADIUS_RESET = 16'd480;

	// Register indexes of the configuration port.
	localparam logic [7:0] REG_FORGET_TIME  = 8'd0;
	localparam logic [7:0] REG_MATCH_RADIUS = 8'd1;

	localparam logic OP_DETECTION = 1'b0;
	localparam logic OP_END_FRAME = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [15:0] det_x;
		logic [15:0] det_y;
		logic [31:0] frame_time;
	} cta_in_t;

	typedef struct packed {
		logic [31:0] track_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        seen_now;
		logic        entry_valid;
		logic        last;
		logic        detections_dropped;
		logic        tracks_dropped;
	} cta_out_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [15:0] value;
	} cta_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RSQ,
		ST_RLD,
		ST_AGE,
		ST_MX,
		ST_MY,
		ST_MC,
		ST_NEW,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

/* design/cta_chan_if.sv */
// ----------------------------------------------------------------------------
// Centroid track association channel
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface cta_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/cta_sqr.sv */
// ----------------------------------------------------------------------------
// Centroid track association squarer
// Shared 16-bit unsigned squaring unit with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module cta_sqr import cta_pkg::*; (
	input  wire logic        clk,
	input  wire logic [15:0] a,
	output logic      [31:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * a;
	end

endmodule

`default_nettype wire

/* design/centroid_track_association.sv */
// ----------------------------------------------------------------------------
// Centroid track association
// Nearest-neighbour centroid tracker over one frame of blob detections.
// ----------------------------------------------------------------------------
// Usage: detections arrive on in_ch with operation 0 and are buffered; a
// full buffer drops them and flags the frame. An item with operation 1
// closes the frame: the block ages every live track, matches the unclaimed
// detections against each surviving track, opens new tracks for the rest,
// and reports every live track in slot order on out_ch (or one empty marker
// when none is alive), with last set on the final transfer. A single shared
// squarer does all distance work. in_ch is not ready from the frame close
// until the last report transfer is loaded into the output register, so the
// next frame's detections are taken while that transfer still waits.
// cfg_ch is always ready; writes are meant to happen while the block idles.
// Reset clears all tracks, the buffer, the flags and the identifier counter,
// and loads the registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module centroid_track_association import cta_pkg::*; #(
	parameter int MAX_TRACKS     = CTA_MAX_TRACKS,
	parameter int MAX_DETECTIONS = CTA_MAX_DETECTIONS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cta_chan_if.sink    in_ch,
	cta_chan_if.source  out_ch,
	cta_chan_if.sink    cfg_ch
);

	localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int DW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
	localparam int CW = $clog2(MAX_DETECTIONS + 1);
	localparam logic [TW-1:0] LAST_SLOT = TW'(MAX_TRACKS - 1);
	localparam logic [CW-1:0] DET_FULL  = CW'(MAX_DETECTIONS);

	// Configuration registers.
	logic [15:0] forget_q, radius_q;

	// Detection buffer and track table.
	logic [31:0] det_q    [MAX_DETECTIONS];
	logic [31:0] centre_q [MAX_TRACKS];
	logic [31:0] seen_t_q [MAX_TRACKS];
	logic [31:0] ident_q  [MAX_TRACKS];
	logic [MAX_DETECTIONS-1:0] claimed_q;
	logic [MAX_TRACKS-1:0]     alive_q, seen_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   next_id_q, now_q, r2_q, sqx_q;
	logic          drop_det_q, drop_trk_q;

	// Sequencer.
	state_t state_q, state_d;
	logic [TW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;

	// Output register.
	logic     out_v_q;
	cta_out_t out_q;

	// Shared squarer.
	logic [15:0] mul_a;
	logic [31:0] p_q;

	cta_sqr u_sqr (
		.clk (clk),
		.a   (mul_a),
		.p_q (p_q)
	);

	logic [DW-1:0] jx;
	logic [31:0]   cur_c, det_c, age_c;
	logic [15:0]   adx, ady;
	logic          expired, j_end, hit, out_free, out_load, in_acc;
	logic          free_found, more_alive;
	logic [TW-1:0] free_slot;

	always_comb begin
		jx    = j_q[DW-1:0];
		cur_c = centre_q[i_q];
		det_c = det_q[jx];
		adx   = (cur_c[15:0] >= det_c[15:0]) ? cur_c[15:0] - det_c[15:0]
		                                      : det_c[15:0] - cur_c[15:0];
		ady   = (cur_c[31:16] >= det_c[31:16]) ? cur_c[31:16] - det_c[31:16]
		                                        : det_c[31:16] - cur_c[31:16];
		age_c   = now_q - seen_t_q[i_q];
		expired = age_c > {16'd0, forget_q};
		j_end   = j_q >= cnt_q;
		hit     = ({1'b0, sqx_q} + {1'b0, p_q}) <= {1'b0, r2_q};
		out_free = !out_v_q || out_ch.ready;
		// A report transfer is loaded into the output register this cycle.
		out_load = (state_q == ST_OUT) && out_free && (alive_q == '0 || alive_q[i_q]);

		// Lowest dead slot for a new track.
		free_found = 1'b0;
		free_slot  = '0;
		for (int k = MAX_TRACKS - 1; k >= 0; k--) begin
			if (!alive_q[k]) begin
				free_found = 1'b1;
				free_slot  = TW'(k);
			end
		end

		// Whether a live track follows the current slot in the report.
		more_alive = 1'b0;
		for (int k = 0; k < MAX_TRACKS; k++) begin
			if (k > int'(i_q) && alive_q[k]) more_alive = 1'b1;
		end
	end

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	// Next state and squarer operand.
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		mul_a   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_ch.data.operation == OP_END_FRAME) begin
					state_d = ST_RSQ;
					i_d     = '0;
				end
			end
			ST_RSQ: begin
				mul_a   = radius_q;
				state_d = ST_RLD;
			end
			ST_RLD: state_d = ST_AGE;
			ST_AGE: begin
				if (alive_q[i_q] && !expired) begin
					state_d = ST_MX;
					j_d     = '0;
				end else if (i_q == LAST_SLOT) begin
					state_d = ST_NEW;
					j_d     = '0;
				end else begin
					state_d = ST_AGE;
					i_d     = i_q + 1'b1;
				end
			end
			ST_MX: begin
				mul_a = adx;
				if (j_end) begin
					if (i_q == LAST_SLOT) begin
						state_d = ST_NEW;
						j_d     = '0;
					end else begin
						state_d = ST_AGE;
						i_d     = i_q + 1'b1;
					end
				end else if (claimed_q[jx]) begin
					j_d = j_q + 1'b1;
				end else begin
					state_d = ST_MY;
				end
			end
			ST_MY: begin
				mul_a   = ady;
				state_d = ST_MC;
			end
			ST_MC: begin
				state_d = ST_MX;
				j_d     = j_q + 1'b1;
			end
			ST_NEW: begin
				if (j_end) begin
					state_d = ST_OUT;
					i_d     = '0;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					if (alive_q == '0) begin
						state_d = ST_IDLE;
					end else if (alive_q[i_q] && !more_alive) begin
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forget_q <= CTA_FORGET_RESET;
			radius_q <= CTA_RADIUS_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.data.index)
				REG_FORGET_TIME:  forget_q <= cfg_ch.data.value;
				REG_MATCH_RADIUS: radius_q <= cfg_ch.data.value;
				default: ;
			endcase
		end
	end

	// Control state of the track table and the detection buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			claimed_q  <= '0;
			alive_q    <= '0;
			seen_q     <= '0;
			next_id_q  <= '0;
			drop_det_q <= 1'b0;
			drop_trk_q <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.data.operation == OP_DETECTION) begin
						if (cnt_q < DET_FULL) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							drop_det_q <= 1'b1;
						end
					end
				end
				ST_AGE: begin
					if (alive_q[i_q]) begin
						seen_q[i_q] <= 1'b0;
						if (expired) alive_q[i_q] <= 1'b0;
					end
				end
				ST_MC: begin
					if (hit) begin
						seen_q[i_q]    <= 1'b1;
						claimed_q[jx]  <= 1'b1;
					end
				end
				ST_NEW: begin
					if (!j_end && !claimed_q[jx]) begin
						claimed_q[jx] <= 1'b1;
						if (free_found) begin
							alive_q[free_slot] <= 1'b1;
							seen_q[free_slot]  <= 1'b1;
							next_id_q          <= next_id_q + 1'b1;
						end else begin
							drop_trk_q <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						if (alive_q == '0 || !more_alive) begin
							cnt_q      <= '0;
							claimed_q  <= '0;
							drop_det_q <= 1'b0;
							drop_trk_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload storage: buffer, track fields, working registers, report.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					now_q <= in_ch.data.frame_time;
					if (in_ch.data.operation == OP_DETECTION && cnt_q < DET_FULL) begin
						det_q[cnt_q[DW-1:0]] <= {in_ch.data.det_y, in_ch.data.det_x};
					end
				end
			end
			ST_RLD: r2_q <= p_q;
			ST_MY:  sqx_q <= p_q;
			ST_MC: begin
				if (hit) begin
					centre_q[i_q] <= det_c;
					seen_t_q[i_q] <= now_q;
				end
			end
			ST_NEW: begin
				if (!j_end && !claimed_q[jx] && free_found) begin
					ident_q[free_slot]  <= next_id_q + 1'b1;
					centre_q[free_slot] <= det_c;
					seen_t_q[free_slot] <= now_q;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_q.detections_dropped <= drop_det_q;
					out_q.tracks_dropped     <= drop_trk_q;
					if (alive_q == '0) begin
						out_q.track_id    <= '0;
						out_q.pos_x       <= '0;
						out_q.pos_y       <= '0;
						out_q.seen_now    <= 1'b0;
						out_q.entry_valid <= 1'b0;
						out_q.last        <= 1'b1;
					end else if (alive_q[i_q]) begin
						out_q.track_id    <= ident_q[i_q];
						out_q.pos_x       <= cur_c[15:0];
						out_q.pos_y       <= cur_c[31:16];
						out_q.seen_now    <= seen_q[i_q];
						out_q.entry_valid <= 1'b1;
						out_q.last        <= !more_alive;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
